@@ hw/rtl/assert_macros.svh @@
// Assertion helpers clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/plte_pkg.sv @@
package plte_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;

    localparam logic signed [63:0] INT64_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] INT64_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic [63:0]        UINT64_MAX = 64'hffff_ffff_ffff_ffff;

    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = 64 / MUL_CHUNK;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_VALUE = 3'd2;
    localparam logic [2:0] OP_RMAX  = 3'd3;
    localparam logic [2:0] OP_RMIN  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MERGED    = 3'd1;
    localparam logic [2:0] ST_REJECT    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_RANGE = 3'd4;

    typedef struct packed {
        logic signed [63:0] start_x;
        logic signed [63:0] end_x;
        logic signed [63:0] ref_x;
        logic signed [63:0] ref_y;
        logic signed [63:0] slope;
        logic signed [63:0] start_y;
        logic signed [63:0] end_y;
    } seg_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] rx;
        logic signed [63:0] ry;
        logic signed [63:0] sl;
        logic signed [63:0] x;
    } line_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
    } line_rsp_t;

endpackage

@@ hw/rtl/piecewise_linear_table_evaluator.sv @@
// Clear and unused ops go straight to the output register. Load evaluates the start point on
// the line unit, then rejects, reports full, merges in place, or extends or appends after a
// line evaluation at the end point. Value: a binary search over segment starts, then a line
// evaluation if the key lies inside a segment. Range: two such lookups, then a scan of the
// segments between them. One item at a time; next input transfers once the result is
// registered. Reset clears count, sets convex; table memory is not cleared.
`include "assert_macros.svh"

module piecewise_linear_table_evaluator
    import plte_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [63:0] point_x,
    input  logic signed [63:0] other_x,
    input  logic signed [63:0] point_y,
    input  logic signed [63:0] slope,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] value,
    output logic               in_domain,
    output logic [2:0]         status,
    output logic               convex,
    output logic [$clog2(MAX_SEGMENTS+1)-1:0] segment_count
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCH_CMP, S_SEG, S_SEG_LINE, S_EVAL, S_SCAN, S_SCAN_CHK,
        S_LD_START, S_LD_SY, S_LD_MRG, S_LD_EY, S_FINISH
    } state_t;

    seg_t                mem [MAX_SEGMENTS];
    seg_t                rd_data_reg;

    state_t              state_reg;
    logic [2:0]          op_reg;
    logic signed [63:0]  px_reg;
    logic signed [63:0]  ox_reg;
    logic signed [63:0]  py_reg;
    logic signed [63:0]  sl_reg;
    logic signed [63:0]  sx_reg;
    logic signed [63:0]  ex_reg;
    logic signed [63:0]  key_reg;
    logic                phase_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [IDX_W-1:0]    mid_reg;
    logic [CNT_W-1:0]    s_n_reg;
    logic [CNT_W-1:0]    e_n_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic                dom0_reg;
    logic                dom_reg;
    logic signed [63:0]  v_reg;
    logic signed [63:0]  acc_reg;
    logic signed [63:0]  sy_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                convex_reg;
    seg_t                last_reg;
    logic signed [63:0]  res_value_reg;
    logic                res_dom_reg;
    logic [2:0]          res_status_reg;
    logic                out_valid_reg;
    logic signed [63:0]  out_value_reg;
    logic                out_dom_reg;
    logic [2:0]          out_status_reg;
    logic                out_convex_reg;
    logic [CNT_W-1:0]    out_count_reg;

    line_req_t           lu_req;
    line_rsp_t           lu_rsp;

    logic                in_xfer;
    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    seg_t                mem_wdata;
    logic                have_last;
    logic                ld_reject;
    logic                ld_merge;
    logic                ld_extend;
    logic                ld_full;
    logic                want_max;
    logic                seg_dom;
    logic                take0;
    logic                take1;
    logic signed [63:0]  fold0;
    logic signed [63:0]  fold1;
    logic signed [63:0]  acc_init;

    function automatic logic signed [63:0] fold(input logic want_hi,
                                                input logic signed [63:0] acc,
                                                input logic signed [63:0] c);
        if (want_hi)
            return (c > acc) ? c : acc;
        return (c < acc) ? c : acc;
    endfunction

    plte_line_unit u_line
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lu_req),
        .rsp   (lu_rsp)
    );

    assign in_stall = state_reg != S_IDLE;
    assign in_xfer  = in_valid && !in_stall;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = IDX_W'(mid_sum >> 1);
    assign want_max = op_reg == OP_RMAX;
    assign seg_dom  = rd_data_reg.end_x >= key_reg;
    assign acc_init = want_max ? INT64_MIN : INT64_MAX;

    assign have_last = count_reg != '0;
    assign ld_reject = have_last && (last_reg.end_x > sx_reg);
    assign ld_merge  = have_last && (last_reg.end_x == sx_reg) &&
                       (last_reg.end_y == lu_rsp.value) && (last_reg.slope == sl_reg);
    assign ld_extend = ex_reg > last_reg.end_x;
    assign ld_full   = count_reg >= CNT_W'(MAX_SEGMENTS);

    assign take0 = (rd_data_reg.start_x >= px_reg) && (rd_data_reg.start_x <= ox_reg);
    assign take1 = (rd_data_reg.end_x >= px_reg) && (rd_data_reg.end_x <= ox_reg);
    assign fold0 = take0 ? fold(want_max, acc_reg, rd_data_reg.start_y) : acc_reg;
    assign fold1 = take1 ? fold(want_max, fold0, rd_data_reg.end_y) : fold0;

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = mid;
        mem_we    = 1'b0;
        mem_waddr = count_reg[IDX_W-1:0];
        mem_wdata = last_reg;
        lu_req    = '{start: 1'b0, rx: px_reg, ry: py_reg, sl: sl_reg, x: sx_reg};
        case (state_reg)
            S_SRCH:
            begin
                mem_re = 1'b1;
                if (lo_reg >= hi_reg)
                    mem_raddr = IDX_W'(lo_reg - CNT_W'(1));
            end
            S_SCAN:
            begin
                mem_re    = 1'b1;
                mem_raddr = scan_reg[IDX_W-1:0];
            end
            S_SEG:
            begin
                lu_req = '{start: seg_dom, rx: rd_data_reg.ref_x, ry: rd_data_reg.ref_y,
                           sl: rd_data_reg.slope, x: key_reg};
            end
            S_LD_START:
                lu_req.start = 1'b1;
            S_LD_SY:
            begin
                if (lu_rsp.done && !ld_reject)
                begin
                    if (ld_merge)
                        lu_req = '{start: ld_extend, rx: last_reg.ref_x, ry: last_reg.ref_y,
                                   sl: last_reg.slope, x: ex_reg};
                    else if (!ld_full)
                        lu_req = '{start: 1'b1, rx: px_reg, ry: py_reg, sl: sl_reg,
                                   x: ex_reg};
                end
            end
            S_LD_MRG:
            begin
                mem_we          = lu_rsp.done;
                mem_waddr       = IDX_W'(count_reg - CNT_W'(1));
                mem_wdata.end_x = ex_reg;
                mem_wdata.end_y = lu_rsp.value;
            end
            S_LD_EY:
            begin
                mem_we    = lu_rsp.done;
                mem_wdata = '{start_x: sx_reg, end_x: ex_reg, ref_x: px_reg, ref_y: py_reg,
                              slope: sl_reg, start_y: sy_reg, end_y: lu_rsp.value};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            convex_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            // A finishing item reloads the output register itself.
            if (out_valid_reg && !out_stall && state_reg != S_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg         <= op;
                        px_reg         <= point_x;
                        ox_reg         <= other_x;
                        py_reg         <= point_y;
                        sl_reg         <= slope;
                        sx_reg         <= (point_x < other_x) ? point_x : other_x;
                        ex_reg         <= (point_x < other_x) ? other_x : point_x;
                        key_reg        <= point_x;
                        phase_reg      <= 1'b0;
                        lo_reg         <= '0;
                        hi_reg         <= count_reg;
                        res_value_reg  <= '0;
                        res_dom_reg    <= 1'b0;
                        res_status_reg <= ST_OK;
                        unique case (op) inside
                            OP_CLEAR:
                            begin
                                count_reg  <= '0;
                                convex_reg <= 1'b1;
                                state_reg  <= S_FINISH;
                            end
                            OP_LOAD:
                                state_reg <= S_LD_START;
                            OP_VALUE, OP_RMAX, OP_RMIN:
                                state_reg <= S_SRCH;
                            default:
                                state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_SRCH_CMP;
                    end
                    else if (lo_reg == '0)
                    begin
                        dom_reg   <= 1'b0;
                        v_reg     <= INT64_MAX;
                        state_reg <= S_EVAL;
                    end
                    else
                        state_reg <= S_SEG;
                end
                S_SRCH_CMP:
                begin
                    if (rd_data_reg.start_x <= key_reg)
                        lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
                    else
                        hi_reg <= CNT_W'(mid_reg);
                    state_reg <= S_SRCH;
                end
                S_SEG:
                begin
                    if (seg_dom)
                        state_reg <= S_SEG_LINE;
                    else
                    begin
                        dom_reg   <= 1'b0;
                        v_reg     <= INT64_MAX;
                        state_reg <= S_EVAL;
                    end
                end
                S_SEG_LINE:
                begin
                    if (lu_rsp.done)
                    begin
                        dom_reg   <= 1'b1;
                        v_reg     <= lu_rsp.value;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (!phase_reg)
                    begin
                        dom0_reg    <= dom_reg;
                        s_n_reg     <= lo_reg;
                        res_dom_reg <= dom_reg;
                        if (op_reg == OP_VALUE)
                        begin
                            res_value_reg <= v_reg;
                            state_reg     <= S_FINISH;
                        end
                        else if (ox_reg < px_reg)
                        begin
                            res_value_reg  <= INT64_MAX;
                            res_status_reg <= ST_BAD_RANGE;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            acc_reg   <= dom_reg ? v_reg : acc_init;
                            phase_reg <= 1'b1;
                            key_reg   <= ox_reg;
                            lo_reg    <= '0;
                            hi_reg    <= count_reg;
                            state_reg <= S_SRCH;
                        end
                    end
                    else
                    begin
                        e_n_reg <= lo_reg;
                        if (dom_reg)
                            acc_reg <= fold(want_max, acc_reg, v_reg);
                        // Range that starts and ends in the same hole, or before the domain.
                        if (s_n_reg == lo_reg && (s_n_reg == '0 || !dom0_reg))
                        begin
                            res_value_reg <= INT64_MAX;
                            state_reg     <= S_FINISH;
                        end
                        else
                        begin
                            scan_reg  <= (s_n_reg == '0) ? '0 : s_n_reg - CNT_W'(1);
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg < e_n_reg)
                        state_reg <= S_SCAN_CHK;
                    else
                    begin
                        res_value_reg <= acc_reg;
                        state_reg     <= S_FINISH;
                    end
                end
                S_SCAN_CHK:
                begin
                    acc_reg   <= fold1;
                    scan_reg  <= scan_reg + CNT_W'(1);
                    state_reg <= S_SCAN;
                end
                S_LD_START:
                    state_reg <= S_LD_SY;
                S_LD_SY:
                begin
                    if (lu_rsp.done)
                    begin
                        sy_reg <= lu_rsp.value;
                        if (ld_reject)
                        begin
                            res_status_reg <= ST_REJECT;
                            state_reg      <= S_FINISH;
                        end
                        else if (ld_merge)
                        begin
                            res_status_reg <= ST_MERGED;
                            state_reg      <= ld_extend ? S_LD_MRG : S_FINISH;
                        end
                        else if (ld_full)
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_FINISH;
                        end
                        else
                            state_reg <= S_LD_EY;
                    end
                end
                S_LD_MRG:
                begin
                    if (lu_rsp.done)
                    begin
                        last_reg.end_x <= ex_reg;
                        last_reg.end_y <= lu_rsp.value;
                        state_reg      <= S_FINISH;
                    end
                end
                S_LD_EY:
                begin
                    if (lu_rsp.done)
                    begin
                        last_reg <= mem_wdata;
                        if (have_last && !(sl_reg >= last_reg.slope &&
                                           sx_reg == last_reg.end_x &&
                                           sy_reg == last_reg.end_y))
                            convex_reg <= 1'b0;
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // Hold until the output register is free.
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_dom_reg    <= res_dom_reg;
                        out_status_reg <= res_status_reg;
                        out_convex_reg <= convex_reg;
                        out_count_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign value         = out_value_reg;
    assign in_domain     = out_dom_reg;
    assign status        = out_status_reg;
    assign convex        = out_convex_reg;
    assign segment_count = out_count_reg;

    `ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_SEGMENTS), "count past depth")
    `ASSERT_NEXT(a_accept_busy, in_xfer, state_reg != S_IDLE, "transfer did not start work")
    `ASSERT_IMPLIES(a_append_room, mem_we && state_reg == S_LD_EY, !ld_full, "append when full")
    `ASSERT_IMPLIES(a_convex_short, count_reg <= CNT_W'(1), convex_reg, "convex lost early")

endmodule

@@ hw/rtl/plte_line_unit.sv @@
module plte_line_unit
    import plte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  line_req_t req,
    output line_rsp_t rsp
);

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_FIN} lstate_t;

    localparam int STEP_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;

    lstate_t                   state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [63:0]               dm_reg;
    logic [63:0]               sm_reg;
    logic [63:0]               rm_reg;
    logic                      pneg_reg;
    logic                      rneg_reg;
    logic [127:0]              acc_reg;
    logic signed [63:0]        value_reg;
    logic                      done_reg;

    logic                      dneg;
    logic [63:0]               dm;
    logic [63:0]               sm;
    logic [63:0]               rm;
    logic [63+MUL_CHUNK:0]     pp;
    logic [63:0]               pm;
    logic                      pneg_e;
    logic [64:0]               sum;
    logic                      res_neg;
    logic [63:0]               res_mag;
    logic signed [63:0]        res_val;

    always_comb
    begin
        dneg = req.x < req.rx;
        dm   = dneg ? 64'(req.rx - req.x) : 64'(req.x - req.rx);
        sm   = req.sl[63] ? 64'(-req.sl) : 64'(req.sl);
        rm   = req.ry[63] ? 64'(-req.ry) : 64'(req.ry);
        pp   = dm_reg * sm_reg[63 -: MUL_CHUNK];
    end

    // Combine saturated product magnitude with ref_y, then saturate to int64.
    always_comb
    begin
        pm      = (|acc_reg[127:64]) ? UINT64_MAX : acc_reg[63:0];
        pneg_e  = pneg_reg && (pm != 64'd0);
        sum     = {1'b0, pm} + {1'b0, rm_reg};
        if (pneg_e == rneg_reg)
        begin
            res_neg = pneg_e;
            res_mag = sum[64] ? UINT64_MAX : sum[63:0];
        end
        else if (pm >= rm_reg)
        begin
            res_neg = pneg_e;
            res_mag = pm - rm_reg;
        end
        else
        begin
            res_neg = rneg_reg;
            res_mag = rm_reg - pm;
        end
        if (!res_neg)
            res_val = res_mag[63] ? INT64_MAX : $signed(res_mag);
        else
            res_val = res_mag[63] ? INT64_MIN : $signed(64'(-res_mag));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (req.start)
                    begin
                        dm_reg    <= dm;
                        sm_reg    <= sm;
                        rm_reg    <= rm;
                        pneg_reg  <= dneg != req.sl[63];
                        rneg_reg  <= req.ry[63];
                        acc_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    // Take one slope chunk a cycle, most significant first.
                    acc_reg  <= (acc_reg << MUL_CHUNK) + 128'(pp);
                    sm_reg   <= sm_reg << MUL_CHUNK;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(MUL_STEPS - 1))
                        state_reg <= L_FIN;
                end
                L_FIN:
                begin
                    value_reg <= res_val;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

@@ tb/tb_piecewise_linear_table_evaluator.sv @@
`timescale 1ns / 100ps

module tb_piecewise_linear_table_evaluator
    import plte_pkg::*;
();

    localparam int NSEG = MAX_SEGMENTS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [63:0] value;
        logic               dom;
        logic [2:0]         st;
        logic               cvx;
        logic [6:0]         cnt;
    } result_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [63:0] px;
        logic signed [63:0] ox;
        logic signed [63:0] py;
        logic signed [63:0] sl;
        logic               typed;
        logic signed [63:0] tv;
        logic [2:0]         ts;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         op = OP_CLEAR;
    logic signed [63:0] point_x = '0;
    logic signed [63:0] other_x = '0;
    logic signed [63:0] point_y = '0;
    logic signed [63:0] slope = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] value;
    logic               in_domain;
    logic [2:0]         status;
    logic               convex;
    logic [6:0]         segment_count;

    // model of the segment table
    logic signed [63:0] tab_sx [NSEG];
    logic signed [63:0] tab_ex [NSEG];
    logic signed [63:0] tab_rx [NSEG];
    logic signed [63:0] tab_ry [NSEG];
    logic signed [63:0] tab_sl [NSEG];
    logic signed [63:0] tab_sy [NSEG];
    logic signed [63:0] tab_ey [NSEG];
    int                 tab_cnt = 0;
    logic               tab_convex = 1'b1;

    result_t pending_results[$];
    int      errors = 0;
    int      send_idle_pct = 12;
    int      recv_stall_pct = 47;
    int      idle_cycles = 0;
    int      n_sent = 0;
    row_t    directed[$];

    piecewise_linear_table_evaluator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .point_x(point_x), .other_x(other_x), .point_y(point_y), .slope(slope),
        .out_valid(out_valid), .out_stall(out_stall),
        .value(value), .in_domain(in_domain), .status(status), .convex(convex),
        .segment_count(segment_count)
    );

    always #5 clk = ~clk;

    // exact line value, saturated to 64 bits
    function automatic logic signed [63:0] line_at(logic signed [63:0] rx,
        logic signed [63:0] ry, logic signed [63:0] sl, logic signed [63:0] x);
        logic signed [131:0] xe, rxe, rye, sle, p;
        xe = x;
        rxe = rx;
        rye = ry;
        sle = sl;
        p = rye + sle * (xe - rxe);
        if (p > 132'sh7fff_ffff_ffff_ffff)
            return INT64_MAX;
        if (p < -132'sh8000_0000_0000_0000)
            return INT64_MIN;
        return p[63:0];
    endfunction

    function automatic int seg_for(logic signed [63:0] x);
        int idx;
        idx = -1;
        for (int i = 0; i < tab_cnt; i++)
        begin
            if (tab_sx[i] <= x)
                idx = i;
            else
                break;
        end
        return idx;
    endfunction

    function automatic logic covers(logic signed [63:0] x);
        int idx;
        idx = seg_for(x);
        return idx >= 0 && tab_ex[idx] >= x;
    endfunction

    function automatic logic signed [63:0] eval_at(logic signed [63:0] x);
        int idx;
        idx = seg_for(x);
        if (idx < 0 || tab_ex[idx] < x)
            return INT64_MAX;
        return line_at(tab_rx[idx], tab_ry[idx], tab_sl[idx], x);
    endfunction

    function automatic logic better(logic want_max, logic signed [63:0] c,
        logic signed [63:0] acc);
        return want_max ? (c > acc) : (c < acc);
    endfunction

    function automatic logic signed [63:0] range_extreme(logic signed [63:0] rs,
        logic signed [63:0] re, logic want_max);
        int s, e;
        logic signed [63:0] acc;
        s = seg_for(rs);
        e = seg_for(re);
        acc = want_max ? INT64_MIN : INT64_MAX;
        if (s == e && (s < 0 || tab_ex[s] < rs))
            return INT64_MAX;
        if (covers(rs) && better(want_max, eval_at(rs), acc))
            acc = eval_at(rs);
        if (covers(re) && better(want_max, eval_at(re), acc))
            acc = eval_at(re);
        for (int i = (s < 0 ? 0 : s); i <= e; i++)
        begin
            if (tab_sx[i] >= rs && tab_sx[i] <= re && better(want_max, tab_sy[i], acc))
                acc = tab_sy[i];
            if (tab_ex[i] >= rs && tab_ex[i] <= re && better(want_max, tab_ey[i], acc))
                acc = tab_ey[i];
        end
        return acc;
    endfunction

    function automatic void write_seg(int i, logic signed [63:0] px,
        logic signed [63:0] ox, logic signed [63:0] py, logic signed [63:0] sl);
        tab_sx[i] = px < ox ? px : ox;
        tab_ex[i] = px < ox ? ox : px;
        tab_rx[i] = px;
        tab_ry[i] = py;
        tab_sl[i] = sl;
        tab_sy[i] = line_at(px, py, sl, tab_sx[i]);
        tab_ey[i] = line_at(px, py, sl, tab_ex[i]);
    endfunction

    function automatic logic [2:0] load_seg(logic signed [63:0] px,
        logic signed [63:0] ox, logic signed [63:0] py, logic signed [63:0] sl);
        logic signed [63:0] sx, ex;
        int last;
        sx = px < ox ? px : ox;
        ex = px < ox ? ox : px;
        if (tab_cnt == 0)
        begin
            write_seg(0, px, ox, py, sl);
            tab_cnt = 1;
            return ST_OK;
        end
        last = tab_cnt - 1;
        if (tab_ex[last] > sx)
            return ST_REJECT;
        if (tab_ex[last] == sx && tab_ey[last] == line_at(px, py, sl, sx)
            && tab_sl[last] == sl)
        begin
            if (ex > tab_ex[last])
            begin
                tab_ex[last] = ex;
                tab_ey[last] = line_at(tab_rx[last], tab_ry[last], tab_sl[last], ex);
            end
            return ST_MERGED;
        end
        if (tab_cnt >= NSEG)
            return ST_FULL;
        write_seg(tab_cnt, px, ox, py, sl);
        if (!(tab_sl[tab_cnt] >= tab_sl[last] && tab_sx[tab_cnt] == tab_ex[last]
              && tab_sy[tab_cnt] == tab_ey[last]))
            tab_convex = 1'b0;
        tab_cnt++;
        return ST_OK;
    endfunction

    function automatic result_t evaluate_item(logic [2:0] o, logic signed [63:0] px,
        logic signed [63:0] ox, logic signed [63:0] py, logic signed [63:0] sl);
        result_t r;
        r.value = '0;
        r.dom = 1'b0;
        r.st = ST_OK;
        case (o)
            OP_CLEAR:
            begin
                tab_cnt = 0;
                tab_convex = 1'b1;
            end
            OP_LOAD:
                r.st = load_seg(px, ox, py, sl);
            OP_VALUE:
            begin
                r.dom = covers(px);
                r.value = eval_at(px);
            end
            OP_RMAX, OP_RMIN:
            begin
                r.dom = covers(px);
                if (ox < px)
                begin
                    r.value = INT64_MAX;
                    r.st = ST_BAD_RANGE;
                end
                else
                    r.value = range_extreme(px, ox, o == OP_RMAX);
            end
            default: ;
        endcase
        r.cvx = tab_convex;
        r.cnt = tab_cnt[6:0];
        return r;
    endfunction

    function automatic logic signed [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(logic [2:0] o, logic signed [63:0] px, logic signed [63:0] ox,
        logic signed [63:0] py, logic signed [63:0] sl, logic typed = 1'b0,
        logic signed [63:0] tv = '0, logic [2:0] ts = ST_OK);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        point_x <= px;
        other_x <= ox;
        point_y <= py;
        slope <= sl;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;
        r = evaluate_item(o, px, ox, py, sl);
        if (typed)
        begin
            r.value = tv;
            r.st = ts;
        end
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic add_row(logic [2:0] o, logic signed [63:0] px, logic signed [63:0] ox,
        logic signed [63:0] py, logic signed [63:0] sl, logic typed = 1'b0,
        logic signed [63:0] tv = '0, logic [2:0] ts = ST_OK);
        row_t w;
        w.op = o; w.px = px; w.ox = ox; w.py = py; w.sl = sl;
        w.typed = typed; w.tv = tv; w.ts = ts;
        directed.insert(directed.size(), w);
    endtask

    // pick a query x near the loaded span, or anywhere
    function automatic logic signed [63:0] near_x(logic signed [63:0] lo,
        logic signed [63:0] hi);
        if ($urandom_range(9) == 0 || hi - lo > 64'sd100000)
            return rand64();
        return lo - 5 + $urandom_range(0, int'(hi - lo) + 10);
    endfunction

    task automatic random_burst();
        logic signed [63:0] base, cursor, s, e, sl, py, px, ox, ey;
        int nload, nquery;
        logic [2:0] q;
        send(OP_CLEAR, rand64(), rand64(), rand64(), rand64());
        base = rand64() >>> 24;
        cursor = base;
        nload = ($urandom_range(7) == 0) ? 70 : $urandom_range(1, 10);
        for (int k = 0; k < nload; k++)
        begin
            if ($urandom_range(19) == 0)
            begin
                send(OP_LOAD, rand64(), rand64(), rand64(), rand64());
                continue;
            end
            s = cursor;
            if ($urandom_range(9) == 0)
                s = cursor - $urandom_range(1, 20);
            else if ($urandom_range(9) < 4 && k > 0)
                s = cursor + $urandom_range(1, 50);
            e = s + $urandom_range(0, 40);
            ey = (tab_cnt > 0) ? tab_ey[tab_cnt - 1] : 64'sd0;
            if (tab_cnt > 0 && $urandom_range(2) == 0)
                sl = tab_sl[tab_cnt - 1];
            else if ($urandom_range(15) == 0)
                sl = rand64();
            else
                sl = $signed(64'($urandom_range(0, 200))) - 100;
            if ($urandom_range(3) == 0)
                py = rand64() >>> $urandom_range(0, 63);
            else
                py = (s == cursor) ? ey : $signed(64'($urandom_range(0, 2000))) - 1000;
            // keep the line through py at s, then pick which end to reference
            if ($urandom_range(1) == 0)
            begin
                px = s; ox = e;
            end
            else
            begin
                px = e; ox = s; py = py + sl * (e - s);
            end
            send(OP_LOAD, px, ox, py, sl);
            if (e > cursor)
                cursor = e;
        end
        nquery = $urandom_range(2, 8);
        for (int k = 0; k < nquery; k++)
        begin
            q = $urandom_range(9) == 0 ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                       : 3'($urandom_range(OP_VALUE, OP_RMIN));
            px = near_x(base, cursor);
            ox = ($urandom_range(4) == 0) ? near_x(base, cursor)
                                          : px + $urandom_range(0, 60);
            send(q, px, ox, rand64(), rand64());
        end
    endtask

    always @(posedge clk)
    begin
        result_t x;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                x = pending_results.pop_front();
                if (value !== x.value)
                begin
                    $error("value: expected %0d, got %0d", x.value, value);
                    errors++;
                end
                if (in_domain !== x.dom)
                begin
                    $error("in_domain: expected %0d, got %0d", x.dom, in_domain);
                    errors++;
                end
                if (status !== x.st)
                begin
                    $error("status: expected %0d, got %0d", x.st, status);
                    errors++;
                end
                if (convex !== x.cvx)
                begin
                    $error("convex: expected %0d, got %0d", x.cvx, convex);
                    errors++;
                end
                if (segment_count !== x.cnt)
                begin
                    $error("segment_count: expected %0d, got %0d", x.cnt, segment_count);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        add_row(OP_VALUE, 64'sd5, 64'sd0, 64'sd0, 64'sd0, 1'b1, INT64_MAX, ST_OK);
        add_row(OP_RMAX, INT64_MIN, INT64_MAX, 64'sd0, 64'sd0, 1'b1, INT64_MAX, ST_OK);
        add_row(OP_LOAD, 64'sd0, 64'sd10, 64'sd5, 64'sd2, 1'b1, 64'sd0, ST_OK);
        add_row(OP_LOAD, 64'sd20, 64'sd10, 64'sd0, 64'sd1);
        add_row(OP_LOAD, 64'sd5, 64'sd30, 64'sd0, 64'sd1, 1'b1, 64'sd0, ST_REJECT);
        add_row(OP_LOAD, 64'sd20, 64'sd40, 64'sd0, 64'sd1, 1'b1, 64'sd0, ST_MERGED);
        add_row(OP_LOAD, 64'sd45, 64'sd50, 64'sd7, -64'sd3);
        add_row(OP_VALUE, 64'sd15, 64'sd0, 64'sd0, 64'sd0);
        add_row(OP_VALUE, 64'sd42, 64'sd0, 64'sd0, 64'sd0, 1'b1, INT64_MAX, ST_OK);
        add_row(OP_VALUE, INT64_MIN, 64'sd0, 64'sd0, 64'sd0, 1'b1, INT64_MAX, ST_OK);
        add_row(OP_RMAX, 64'sd0, 64'sd50, 64'sd0, 64'sd0);
        add_row(OP_RMIN, -64'sd3, 64'sd47, 64'sd0, 64'sd0);
        add_row(OP_RMIN, 64'sd41, 64'sd44, 64'sd0, 64'sd0, 1'b1, INT64_MAX, ST_OK);
        add_row(OP_RMAX, 64'sd40, 64'sd0, 64'sd0, 64'sd0, 1'b1, INT64_MAX, ST_BAD_RANGE);
        add_row(OP_SPARE_LO, 64'sd1, 64'sd2, 64'sd3, 64'sd4, 1'b1, 64'sd0, ST_OK);
        add_row(OP_CLEAR, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 1'b1, 64'sd0, ST_OK);
        add_row(OP_LOAD, INT64_MIN, INT64_MAX, INT64_MAX, INT64_MAX);
        add_row(OP_VALUE, INT64_MAX, 64'sd0, 64'sd0, 64'sd0);
        add_row(OP_VALUE, INT64_MIN, 64'sd0, 64'sd0, 64'sd0);
        add_row(OP_RMIN, INT64_MIN, INT64_MAX, 64'sd0, 64'sd0);
        add_row(OP_CLEAR, 64'sd0, 64'sd0, 64'sd0, 64'sd0);
        add_row(OP_LOAD, 64'sd0, 64'sd0, INT64_MIN, INT64_MIN);
        add_row(OP_RMAX, INT64_MIN, INT64_MAX, 64'sd0, 64'sd0);
        add_row(OP_SPARE_HI, -64'sd1, -64'sd1, -64'sd1, -64'sd1, 1'b1, 64'sd0, ST_OK);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i].op, directed[i].px, directed[i].ox, directed[i].py,
                 directed[i].sl, directed[i].typed, directed[i].tv, directed[i].ts);

        while (n_sent < 800)
        begin
            // swap idle rates after a third, then run flat out
            if (n_sent >= 533)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            else if (n_sent >= 267)
            begin
                send_idle_pct = 47;
                recv_stall_pct = 12;
            end
            random_burst();
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
